FILE: src/assert_macros.svh
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// implication checked in the following cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

FILE: src/aksq_pkg.sv
// Types and constants of the alpha key sort queue
`default_nettype none
package aksq_pkg;
	localparam int KeyInW  = 39;
	localparam int OffW    = 24;
	localparam int LimitW  = 38;
	localparam int BiasW   = 24;
	localparam int KeyW    = 40;
	localparam int TagW    = 16;
	localparam int CfgW    = 38;
	localparam int CfgIdxW = 2;

	localparam logic [CfgIdxW-1:0] REG_LIMIT    = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_TOP_BIAS = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_MID_BIAS = 2'd2;
	localparam logic [CfgIdxW-1:0] REG_LOW_BIAS = 2'd3;

	localparam logic [LimitW-1:0] LIMIT_RST    = 38'd137438953472;
	localparam logic [BiasW-1:0]  TOP_BIAS_RST = 24'd7680000;
	localparam logic [BiasW-1:0]  MID_BIAS_RST = 24'd5120000;
	localparam logic [BiasW-1:0]  LOW_BIAS_RST = 24'd2560000;

	typedef struct packed {
		logic signed [KeyW-1:0] key;
		logic [TagW-1:0]        obj;
		logic [TagW-1:0]        xf;
		logic [TagW-1:0]        page;
	} entry_t;

	typedef struct packed {
		logic [LimitW-1:0] limit;
		logic [BiasW-1:0]  top_bias;
		logic [BiasW-1:0]  mid_bias;
		logic [BiasW-1:0]  low_bias;
	} cfg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} state_t;
endpackage
`default_nettype wire

FILE: src/aksq_if.sv
// Item channel interfaces of the alpha key sort queue
`default_nettype none
interface aksq_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [aksq_pkg::KeyInW-1:0]  sort_key;
	logic signed [aksq_pkg::OffW-1:0]    depth_offset;
	logic                                top_class;
	logic                                mid_class;
	logic                                low_class;
	logic [aksq_pkg::TagW-1:0]           object_tag;
	logic [aksq_pkg::TagW-1:0]           transform_tag;
	logic [aksq_pkg::TagW-1:0]           blit_page;
	logic                                frame_end;
	modport source (output valid, sort_key, depth_offset, top_class, mid_class, low_class,
		object_tag, transform_tag, blit_page, frame_end, input ready);
	modport sink (input valid, sort_key, depth_offset, top_class, mid_class, low_class,
		object_tag, transform_tag, blit_page, frame_end, output ready);
endinterface

interface aksq_out_if;
	logic                              valid;
	logic                              ready;
	logic [aksq_pkg::TagW-1:0]         out_object_tag;
	logic [aksq_pkg::TagW-1:0]         out_transform_tag;
	logic [aksq_pkg::TagW-1:0]         out_page;
	logic signed [aksq_pkg::KeyW-1:0]  final_key;
	logic                              last_of_run;
	logic                              overflowed;
	modport source (output valid, out_object_tag, out_transform_tag, out_page, final_key,
		last_of_run, overflowed, input ready);
	modport sink (input valid, out_object_tag, out_transform_tag, out_page, final_key,
		last_of_run, overflowed, output ready);
endinterface
`default_nettype wire

FILE: src/aksq_key_adjust.sv
// Key clamp, offset and class bias
`default_nettype none
module aksq_key_adjust (
	input  wire logic signed [aksq_pkg::KeyInW-1:0] sort_key,
	input  wire logic signed [aksq_pkg::OffW-1:0]   depth_offset,
	input  wire logic                               top_class,
	input  wire logic                               mid_class,
	input  wire logic                               low_class,
	input  wire aksq_pkg::cfg_t                     cfg,
	output logic signed [aksq_pkg::KeyW-1:0]        final_key
);
	logic signed [aksq_pkg::KeyInW-1:0] limit_s;
	logic signed [aksq_pkg::KeyInW-1:0] clamped;
	logic [aksq_pkg::BiasW-1:0]         bias;
	logic signed [aksq_pkg::KeyW:0]     sum;

	always_comb begin
		limit_s = signed'({1'b0, cfg.limit});
		clamped = (sort_key > limit_s) ? limit_s : sort_key;
		if (top_class) begin
			bias = cfg.top_bias;
		end else if (mid_class) begin
			bias = cfg.mid_bias;
		end else if (low_class) begin
			bias = cfg.low_bias;
		end else begin
			bias = '0;
		end
		sum = (aksq_pkg::KeyW+1)'(clamped) + (aksq_pkg::KeyW+1)'(depth_offset)
			- signed'((aksq_pkg::KeyW+1)'(bias));
		final_key = sum[aksq_pkg::KeyW-1:0];
	end
endmodule
`default_nettype wire

FILE: src/aksq_store.sv
// Entry memory with one write port and one registered read port
`default_nettype none
module aksq_store #(
	parameter int QUEUE_DEPTH = 64,
	localparam int AW = $clog2(QUEUE_DEPTH)
) (
	input  wire logic            clk,
	input  wire logic            wr_en,
	input  wire logic [AW-1:0]   wr_addr,
	input  wire aksq_pkg::entry_t wr_data,
	input  wire logic            rd_en,
	input  wire logic [AW-1:0]   rd_addr,
	output aksq_pkg::entry_t     rd_data
);
	aksq_pkg::entry_t mem [QUEUE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule
`default_nettype wire

FILE: src/alpha_key_sort_queue_unit.sv
// Top level of the alpha key sort queue
// Input: an entry is stored in the cycle it is accepted unless the queue is full, one item per cycle between flushes.
// Flush: each result takes one scan of the n stored entries through the memory read port,
// and the result then waits until the output takes it; a run of n entries takes n scans.
// No item is accepted during a flush run.
// Reset: the configuration registers return to their defaults, the queue is empty and the drop flag clear.
`default_nettype none
`include "assert_macros.svh"
module alpha_key_sort_queue_unit #(
	parameter int QUEUE_DEPTH = 64
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	aksq_in_if.sink                              in_ch,
	aksq_out_if.source                           out_ch,
	input  wire logic                            cfg_we,
	input  wire logic [aksq_pkg::CfgIdxW-1:0]    cfg_index,
	input  wire logic [aksq_pkg::CfgW-1:0]       cfg_data
);
	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	aksq_pkg::cfg_t   cfg_q;
	aksq_pkg::state_t state_q, state_nxt;
	logic [CW-1:0]    count_q, left_q, rd_ptr_q;
	logic             drop_q;
	logic [QUEUE_DEPTH-1:0] emitted_q;
	logic             vld_s1;
	logic [AW-1:0]    idx_s1;
	logic             best_vld_q;
	aksq_pkg::entry_t best_q, best_nxt;
	logic [AW-1:0]    best_idx_q, best_idx_nxt;
	aksq_pkg::entry_t out_q;
	logic [AW-1:0]    out_idx_q;

	logic             accept, full, store, issue, take, scan_last, out_fire;
	logic signed [aksq_pkg::KeyW-1:0] adj_key;
	aksq_pkg::entry_t wr_data, rd_data;

	aksq_key_adjust u_adjust (
		.sort_key    (in_ch.sort_key),
		.depth_offset(in_ch.depth_offset),
		.top_class   (in_ch.top_class),
		.mid_class   (in_ch.mid_class),
		.low_class   (in_ch.low_class),
		.cfg         (cfg_q),
		.final_key   (adj_key)
	);

	aksq_store #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_store (
		.clk    (clk),
		.wr_en  (store),
		.wr_addr(count_q[AW-1:0]),
		.wr_data(wr_data),
		.rd_en  (issue),
		.rd_addr(rd_ptr_q[AW-1:0]),
		.rd_data(rd_data)
	);

	always_comb begin
		accept   = in_ch.valid && in_ch.ready;
		full     = count_q >= CW'(QUEUE_DEPTH);
		store    = accept && !full;
		wr_data  = '{key: adj_key, obj: in_ch.object_tag, xf: in_ch.transform_tag,
			page: in_ch.blit_page};
		issue    = (state_q == aksq_pkg::ST_SCAN) && (rd_ptr_q < count_q);
		take     = vld_s1 && !emitted_q[idx_s1] && (!best_vld_q || rd_data.key > best_q.key);
		best_nxt = take ? rd_data : best_q;
		best_idx_nxt = take ? idx_s1 : best_idx_q;
		scan_last = vld_s1 && (CW'(idx_s1) + CW'(1) == count_q);
		out_fire = out_ch.valid && out_ch.ready;
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			aksq_pkg::ST_IDLE: begin
				if (accept && in_ch.frame_end) state_nxt = aksq_pkg::ST_SCAN;
			end
			aksq_pkg::ST_SCAN: begin
				if (scan_last) state_nxt = aksq_pkg::ST_EMIT;
			end
			aksq_pkg::ST_EMIT: begin
				if (out_fire) begin
					state_nxt = (left_q == CW'(1)) ? aksq_pkg::ST_IDLE : aksq_pkg::ST_SCAN;
				end
			end
			default: state_nxt = aksq_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ch.ready              = (state_q == aksq_pkg::ST_IDLE);
		out_ch.valid             = (state_q == aksq_pkg::ST_EMIT);
		out_ch.out_object_tag    = out_q.obj;
		out_ch.out_transform_tag = out_q.xf;
		out_ch.out_page          = out_q.page;
		out_ch.final_key         = out_q.key;
		out_ch.last_of_run       = (left_q == CW'(1));
		out_ch.overflowed        = drop_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{limit: aksq_pkg::LIMIT_RST, top_bias: aksq_pkg::TOP_BIAS_RST,
				mid_bias: aksq_pkg::MID_BIAS_RST, low_bias: aksq_pkg::LOW_BIAS_RST};
		end else if (cfg_we) begin
			case (cfg_index)
				aksq_pkg::REG_LIMIT:    cfg_q.limit    <= cfg_data[aksq_pkg::LimitW-1:0];
				aksq_pkg::REG_TOP_BIAS: cfg_q.top_bias <= cfg_data[aksq_pkg::BiasW-1:0];
				aksq_pkg::REG_MID_BIAS: cfg_q.mid_bias <= cfg_data[aksq_pkg::BiasW-1:0];
				aksq_pkg::REG_LOW_BIAS: cfg_q.low_bias <= cfg_data[aksq_pkg::BiasW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= aksq_pkg::ST_IDLE;
			count_q    <= '0;
			left_q     <= '0;
			drop_q     <= 1'b0;
			rd_ptr_q   <= '0;
			vld_s1     <= 1'b0;
			best_vld_q <= 1'b0;
			emitted_q  <= '0;
		end else begin
			state_q <= state_nxt;
			vld_s1  <= issue;
			if (issue) rd_ptr_q <= rd_ptr_q + CW'(1);
			if (vld_s1) best_vld_q <= best_vld_q || take;
			if (accept) begin
				if (store) count_q <= count_q + CW'(1);
				else drop_q <= 1'b1;
				if (in_ch.frame_end) begin
					left_q <= store ? count_q + CW'(1) : count_q;
				end
			end
			if (out_fire) begin
				rd_ptr_q   <= '0;
				best_vld_q <= 1'b0;
				left_q     <= left_q - CW'(1);
				if (left_q == CW'(1)) begin
					count_q   <= '0;
					drop_q    <= 1'b0;
					emitted_q <= '0;
				end else begin
					emitted_q[out_idx_q] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) idx_s1 <= rd_ptr_q[AW-1:0];
		best_q     <= best_nxt;
		best_idx_q <= best_idx_nxt;
		if (scan_last) begin
			out_q     <= best_nxt;
			out_idx_q <= best_idx_nxt;
		end
	end

	`ASSERT_SAME(a_no_accept_while_emit, clk, arst_n, out_ch.valid, !in_ch.ready)
	`ASSERT_SAME(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(QUEUE_DEPTH))
	`ASSERT_NEXT(a_clear_after_run, clk, arst_n, out_fire && out_ch.last_of_run,
		count_q == '0 && !drop_q)
endmodule
`default_nettype wire
